FILE: rtl/hevc_aua_pkg.sv
// ----------------------------------------------------------------------------
// HEVC access unit assembler package
// Shared request and result types, NAL type codes and lane constants.
// ----------------------------------------------------------------------------
package hevc_aua_pkg;

  // NAL unit type codes
  localparam logic [5:0] NalVps    = 6'd32;
  localparam logic [5:0] NalSps    = 6'd33;
  localparam logic [5:0] NalPps    = 6'd34;
  localparam logic [5:0] NalIrapLo = 6'd16;
  localparam logic [5:0] NalIrapHi = 6'd23;

  // Lanes carried per request and lanes that get classified
  localparam int unsigned NalTypesMax = 3;
  localparam int unsigned NalLanes    = 3;

  // Width of the byte count in a result
  localparam int unsigned UnitBytesW = 24;

  typedef struct packed {
    logic [31:0] rtp_timestamp;
    logic [31:0] source_id;
    logic [15:0] profile_key;
    logic        discontinuity;
    logic        payload_valid;
    logic [15:0] payload_bytes;
    logic        marker;
    logic        fragment_open;
    logic [1:0]  nal_count;
    logic [5:0]  nal_type_a;
    logic [5:0]  nal_type_b;
    logic [5:0]  nal_type_c;
  } hevc_aua_in_t;

  typedef struct packed {
    logic                  unit_ready;
    logic                  unit_dropped;
    logic [31:0]           unit_timestamp;
    logic [31:0]           unit_source_id;
    logic [15:0]           unit_profile_key;
    logic [UnitBytesW-1:0] unit_byte_count;
    logic                  saw_vps;
    logic                  saw_sps;
    logic                  saw_pps;
    logic                  saw_irap;
    logic                  random_access_ready;
  } hevc_aua_out_t;

  // Parameter set and IRAP seen flags of one unit
  typedef struct packed {
    logic irap;
    logic pps;
    logic sps;
    logic vps;
  } hevc_aua_seen_t;

endpackage

FILE: rtl/hevc_access_unit_assembler_top.sv
// ----------------------------------------------------------------------------
// HEVC access unit assembler top level
// Groups depacketized RTP packet descriptors into HEVC access units.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one packet
//   descriptor per request. Output channel (out_valid_o / out_ready_i /
//   out_data_o) returns exactly one result per request, in order: emitted
//   unit fields when unit_ready is set, unit_dropped when a unit was
//   discarded, zeros in the unit fields otherwise.
//   From acceptance to out_valid_o the input register holds the request, the
//   unit tracker folds it into the open unit and the result register
//   captures its outcome. Throughput is one request per cycle while the
//   receiver keeps up; the unit state is read and written in the same cycle
//   as the request advances.
//   When the receiver stalls, the result register holds its request and the
//   input register fills; in_ready_o falls only once both are occupied and
//   rises again in the cycle the output is taken.
//   Reset empties both registers and closes the open unit; no clearing pass.
// ----------------------------------------------------------------------------
module hevc_access_unit_assembler_top
  import hevc_aua_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hevc_aua_in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hevc_aua_out_t out_data_o
);

  logic          in_vld_q, in_vld_d;
  hevc_aua_in_t  in_q, in_d;
  logic          out_vld_q, out_vld_d;
  hevc_aua_out_t out_q, out_d;
  hevc_aua_out_t res;
  logic          adv;

  // Advance the held request when the result register is free or draining
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  hevc_aua_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (in_q),
    .res_o  (res)
  );

  // Load the input register on an accepted request
  always_comb begin
    in_vld_d = in_vld_q;
    in_d     = in_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
      in_d     = in_data_i;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  // Capture the result, or drop it once taken
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (adv) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !adv)
    else $error("result overwritten while stalled");

  // Every advanced request shows up as a valid result next cycle
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced request produced no result");

  // Ready stays high while the input register is empty
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("input refused while empty");

endmodule

FILE: rtl/hevc_aua_nal_class.sv
// ----------------------------------------------------------------------------
// HEVC access unit assembler NAL classifier
// Flags VPS, SPS, PPS and IRAP among the valid NAL type lanes of a request.
// ----------------------------------------------------------------------------
module hevc_aua_nal_class
  import hevc_aua_pkg::*;
(
  input  logic [1:0]     nal_count_i,
  input  logic [5:0]     nal_type_a_i,
  input  logic [5:0]     nal_type_b_i,
  input  logic [5:0]     nal_type_c_i,
  output hevc_aua_seen_t seen_o
);

  logic [NalTypesMax-1:0][5:0] types;
  logic [NalTypesMax-1:0]      lane_en;

  assign types = {nal_type_c_i, nal_type_b_i, nal_type_a_i};

  // Enable a lane below both the request's count and the lane limit
  always_comb begin
    for (int i = 0; i < NalTypesMax; i++) begin
      lane_en[i] = (3'(i) < {1'b0, nal_count_i}) && (i < NalLanes);
    end
  end

  // OR the per-lane matches into the seen flags
  always_comb begin
    seen_o = '0;
    for (int i = 0; i < NalTypesMax; i++) begin
      if (lane_en[i]) begin
        seen_o.vps  = seen_o.vps  | (types[i] == NalVps);
        seen_o.sps  = seen_o.sps  | (types[i] == NalSps);
        seen_o.pps  = seen_o.pps  | (types[i] == NalPps);
        seen_o.irap = seen_o.irap | ((types[i] >= NalIrapLo) && (types[i] <= NalIrapHi));
      end
    end
  end

endmodule

FILE: rtl/hevc_aua_unit.sv
// ----------------------------------------------------------------------------
// HEVC access unit assembler unit tracker
// Holds the open unit, folds in one request per advance and forms its result.
// ----------------------------------------------------------------------------
module hevc_aua_unit
  import hevc_aua_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  hevc_aua_in_t  req_i,
  output hevc_aua_out_t res_o
);

  localparam int unsigned ExtW = (COUNT_BITS > UnitBytesW) ? COUNT_BITS : UnitBytesW;

  logic                  open_q, open_d;
  logic                  corrupt_q, corrupt_d;
  logic [31:0]           ts_q, ts_d;
  logic [31:0]           sid_q, sid_d;
  logic [15:0]           pkey_q, pkey_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  hevc_aua_seen_t        seen_q, seen_d;

  hevc_aua_seen_t        req_seen;
  logic                  keep_open;
  logic                  early_drop;
  logic                  mismatch;
  logic [31:0]           ts_b, sid_b;
  logic [15:0]           pkey_b;
  logic [COUNT_BITS-1:0] cnt_b, cnt_n;
  logic [COUNT_BITS:0]   cnt_sum;
  logic                  corrupt_b, corrupt_n;
  hevc_aua_seen_t        seen_b, seen_n;
  logic                  emit;
  logic [ExtW-1:0]       cnt_ext;

  hevc_aua_nal_class u_nal_class (
    .nal_count_i  (req_i.nal_count),
    .nal_type_a_i (req_i.nal_type_a),
    .nal_type_b_i (req_i.nal_type_b),
    .nal_type_c_i (req_i.nal_type_c),
    .seen_o       (req_seen)
  );

  // Drop the open unit on a break or on a stream key change
  assign mismatch   = (req_i.rtp_timestamp != ts_q) || (req_i.source_id != sid_q) ||
                      (req_i.profile_key != pkey_q);
  assign keep_open  = open_q && !req_i.discontinuity && !mismatch;
  assign early_drop = open_q && !keep_open;

  // Start from the held unit, or open a fresh one on this request
  assign ts_b      = keep_open ? ts_q : req_i.rtp_timestamp;
  assign sid_b     = keep_open ? sid_q : req_i.source_id;
  assign pkey_b    = keep_open ? pkey_q : req_i.profile_key;
  assign cnt_b     = keep_open ? cnt_q : '0;
  assign seen_b    = keep_open ? seen_q : '0;
  assign corrupt_b = keep_open && corrupt_q;

  // Add the payload bytes with saturation and merge NAL flags, or mark the unit corrupt if invalid
  assign cnt_sum = {1'b0, cnt_b} + (COUNT_BITS + 1)'(req_i.payload_bytes);

  always_comb begin
    if (req_i.payload_valid) begin
      cnt_n     = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
      seen_n    = seen_b | req_seen;
      corrupt_n = corrupt_b;
    end else begin
      cnt_n     = cnt_b;
      seen_n    = seen_b;
      corrupt_n = 1'b1;
    end
  end

  assign emit    = req_i.marker && !corrupt_n && !req_i.fragment_open && (cnt_n != '0);
  assign cnt_ext = ExtW'(cnt_n);

  // Form the result: unit fields zero unless a unit is emitted, plus the drop flag
  always_comb begin
    res_o              = '0;
    res_o.unit_dropped = early_drop || (req_i.marker && !emit);
    if (emit) begin
      res_o.unit_ready          = 1'b1;
      res_o.unit_timestamp      = ts_b;
      res_o.unit_source_id      = sid_b;
      res_o.unit_profile_key    = pkey_b;
      res_o.unit_byte_count     = cnt_ext[UnitBytesW-1:0];
      res_o.saw_vps             = seen_n.vps;
      res_o.saw_sps             = seen_n.sps;
      res_o.saw_pps             = seen_n.pps;
      res_o.saw_irap            = seen_n.irap;
      res_o.random_access_ready = &seen_n;
    end
  end

  // On an advance, close the unit on a marker, otherwise hold the updated unit
  always_comb begin
    open_d    = open_q;
    corrupt_d = corrupt_q;
    ts_d      = ts_q;
    sid_d     = sid_q;
    pkey_d    = pkey_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    if (adv_i) begin
      if (req_i.marker) begin
        open_d    = 1'b0;
        corrupt_d = 1'b0;
        ts_d      = '0;
        sid_d     = '0;
        pkey_d    = '0;
        cnt_d     = '0;
        seen_d    = '0;
      end else begin
        open_d    = 1'b1;
        corrupt_d = corrupt_n;
        ts_d      = ts_b;
        sid_d     = sid_b;
        pkey_d    = pkey_b;
        cnt_d     = cnt_n;
        seen_d    = seen_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      corrupt_q <= 1'b0;
      ts_q      <= '0;
      sid_q     <= '0;
      pkey_q    <= '0;
      cnt_q     <= '0;
      seen_q    <= '0;
    end else begin
      open_q    <= open_d;
      corrupt_q <= corrupt_d;
      ts_q      <= ts_d;
      sid_q     <= sid_d;
      pkey_q    <= pkey_d;
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
    end
  end

  // A closed unit carries no leftover count, flags or corruption
  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (cnt_q == '0) && (seen_q == '0) && !corrupt_q)
    else $error("closed unit holds stale state");

  // A marker request always closes the unit
  a_marker_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && req_i.marker |=> !open_q)
    else $error("unit still open after marker");

  // An invalid payload without marker leaves the unit open and corrupt
  a_invalid_corrupts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !req_i.payload_valid && !req_i.marker |=> open_q && corrupt_q)
    else $error("invalid payload did not mark unit corrupt");

  // A break reopens the unit on the request's own timestamp
  a_disc_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && req_i.discontinuity && !req_i.marker |=>
      open_q && (ts_q == $past(req_i.rtp_timestamp)))
    else $error("discontinuity did not reopen unit");

endmodule

FILE: tb/tb_hevc_access_unit_assembler_top.sv
// ----------------------------------------------------------------------------
// HEVC access unit assembler testbench
// Feeds packet descriptor requests through a bursty driver, predicts every
// result with an access unit tracker of its own and checks each result field
// against it while the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_hevc_access_unit_assembler_top;
  import hevc_aua_pkg::*;

  localparam int unsigned COUNT_BITS    = 24;
  localparam int unsigned ITEM_TARGET   = 650;
  localparam int unsigned SAT_PACKETS   = 260;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam logic [COUNT_BITS-1:0] BytesMax = '1;

  typedef enum logic [1:0] {
    SinkOpen,
    SinkCoin,
    SinkChoke
  } sink_mode_e;

  typedef struct packed {
    logic         drain;
    hevc_aua_in_t pkt;
  } pkt_slot_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  hevc_aua_in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  hevc_aua_out_t out_data_o;

  // Pending requests and results still owed by the block
  pkt_slot_t     pkt_q[$];
  hevc_aua_out_t unit_exp_q[$];
  int            results_owed = 0;
  int            err_count    = 0;
  int            n_queued     = 0;
  int            cycle_count  = 0;
  logic          drain_next   = 1'b0;

  // Driver and receiver pacing
  int            burst_left = 0;
  int            gap_left   = 0;
  sink_mode_e    sink_mode  = SinkOpen;
  int            mode_left  = 0;

  // Stream identity shared by consecutive random units
  logic [31:0]   stream_sid  = 32'h1234_5678;
  logic [15:0]   stream_pkey = 16'h00a5;

  // Predicted access unit state
  logic                  au_open;
  logic                  au_corrupt;
  logic [31:0]           au_ts;
  logic [31:0]           au_sid;
  logic [15:0]           au_pkey;
  logic [COUNT_BITS-1:0] au_bytes;
  hevc_aua_seen_t        au_seen;

  hevc_access_unit_assembler_top #(
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Close the tracked unit and clear everything it holds
  function automatic void close_au();
    au_open    = 1'b0;
    au_corrupt = 1'b0;
    au_ts      = '0;
    au_sid     = '0;
    au_pkey    = '0;
    au_bytes   = '0;
    au_seen    = '0;
  endfunction

  // Fold one request into the tracked unit and return the result it causes
  function automatic hevc_aua_out_t assemble_step(input hevc_aua_in_t pkt);
    hevc_aua_out_t         res;
    logic [COUNT_BITS:0]   sum;
    logic [5:0]            nal [3];
    int unsigned           lanes;
    res = '0;
    if (pkt.discontinuity) begin
      res.unit_dropped = au_open;
      close_au();
    end
    if (au_open && (pkt.rtp_timestamp != au_ts || pkt.source_id != au_sid ||
                    pkt.profile_key != au_pkey)) begin
      res.unit_dropped = 1'b1;
      close_au();
    end
    if (!au_open) begin
      au_open = 1'b1;
      au_ts   = pkt.rtp_timestamp;
      au_sid  = pkt.source_id;
      au_pkey = pkt.profile_key;
    end
    if (!pkt.payload_valid) begin
      au_corrupt = 1'b1;
    end else begin
      sum      = au_bytes + pkt.payload_bytes;
      au_bytes = (sum > BytesMax) ? BytesMax : sum[COUNT_BITS-1:0];
      lanes = 32'(pkt.nal_count);
      if (lanes > NalLanes) lanes = NalLanes;
      if (lanes > NalTypesMax) lanes = NalTypesMax;
      nal[0] = pkt.nal_type_a;
      nal[1] = pkt.nal_type_b;
      nal[2] = pkt.nal_type_c;
      for (int i = 0; i < lanes; i++) begin
        if (nal[i] == NalVps) au_seen.vps = 1'b1;
        if (nal[i] == NalSps) au_seen.sps = 1'b1;
        if (nal[i] == NalPps) au_seen.pps = 1'b1;
        if (nal[i] >= NalIrapLo && nal[i] <= NalIrapHi) au_seen.irap = 1'b1;
      end
    end
    if (pkt.marker) begin
      if (au_corrupt || pkt.fragment_open || au_bytes == '0) begin
        res.unit_dropped = 1'b1;
      end else begin
        res.unit_ready          = 1'b1;
        res.unit_timestamp      = au_ts;
        res.unit_source_id      = au_sid;
        res.unit_profile_key    = au_pkey;
        res.unit_byte_count     = au_bytes[UnitBytesW-1:0];
        res.saw_vps             = au_seen.vps;
        res.saw_sps             = au_seen.sps;
        res.saw_pps             = au_seen.pps;
        res.saw_irap            = au_seen.irap;
        res.random_access_ready = &au_seen;
      end
      close_au();
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Stimulus helpers
  function automatic hevc_aua_in_t base_pkt(input logic [31:0] ts, input logic [31:0] sid,
                                            input logic [15:0] pkey,
                                            input logic [15:0] nbytes, input logic mark);
    hevc_aua_in_t p;
    p               = '0;
    p.rtp_timestamp = ts;
    p.source_id     = sid;
    p.profile_key   = pkey;
    p.payload_valid = 1'b1;
    p.payload_bytes = nbytes;
    p.marker        = mark;
    return p;
  endfunction

  function automatic logic [5:0] pick_nal_type();
    case ($urandom_range(0, 5))
      0:       return NalVps;
      1:       return NalSps;
      2:       return NalPps;
      3:       return 6'($urandom_range(NalIrapLo, NalIrapHi));
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [15:0] pick_bytes();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 1500));
    endcase
  endfunction

  function automatic hevc_aua_in_t add_nal(input hevc_aua_in_t p);
    p.nal_count  = 2'($urandom_range(0, 3));
    p.nal_type_a = pick_nal_type();
    p.nal_type_b = pick_nal_type();
    p.nal_type_c = pick_nal_type();
    return p;
  endfunction

  function automatic void queue_pkt(input hevc_aua_in_t p);
    pkt_q.push_back('{drain: drain_next, pkt: p});
    drain_next = 1'b0;
    n_queued++;
  endfunction

  // Queue a well-formed unit with random content, now and then broken
  function automatic void queue_random_unit();
    logic [31:0]  ts;
    logic [15:0]  pkey;
    hevc_aua_in_t p;
    int           npk;
    logic         close_it;
    if ($urandom_range(0, 15) == 0) stream_sid = $urandom;
    if ($urandom_range(0, 15) == 0) stream_pkey = 16'($urandom);
    ts       = $urandom;
    pkey     = stream_pkey;
    npk      = $urandom_range(1, 6);
    close_it = ($urandom_range(0, 9) != 0);
    for (int k = 0; k < npk; k++) begin
      p = base_pkt(ts, stream_sid, pkey, pick_bytes(), close_it && k == npk - 1);
      p = add_nal(p);
      if ($urandom_range(0, 19) == 0) p.payload_valid = 1'b0;
      if (p.marker && $urandom_range(0, 9) == 0) p.fragment_open = 1'b1;
      case ($urandom_range(0, 39))
        0:       p.rtp_timestamp = ts + 1;
        1:       p.source_id     = ~stream_sid;
        2:       p.profile_key   = pkey ^ 16'h0001;
        3:       p.discontinuity = 1'b1;
        default: ;
      endcase
      queue_pkt(p);
    end
  endfunction

  // Queue one unit long enough to saturate the byte count
  function automatic void queue_saturating_unit();
    logic [31:0]  ts;
    hevc_aua_in_t p;
    ts = $urandom;
    for (int k = 0; k < SAT_PACKETS; k++) begin
      p = add_nal(base_pkt(ts, stream_sid, stream_pkey, '1, k == SAT_PACKETS - 1));
      queue_pkt(p);
    end
  endfunction

  function automatic void queue_noise();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    queue_pkt(r[$bits(hevc_aua_in_t)-1:0]);
  endfunction

  // Drive requests in bursts; hold off a drain request until all results are in
  always @(posedge clk_i or negedge rst_ni) begin : pkt_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        in_valid_i <= 1'b0;
      end else if (pkt_q.size() != 0 &&
                   !(pkt_q[0].drain && (in_valid_i || results_owed != 0))) begin
        in_data_i  <= pkt_q[0].pkt;
        in_valid_i <= 1'b1;
        burst_left <= burst_left - 1;
        void'(pkt_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result channel on a pattern that changes every so often
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_mode   <= SinkOpen;
      mode_left   <= 0;
    end else begin
      if (mode_left == 0) begin
        sink_mode <= sink_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (sink_mode)
        SinkOpen: out_ready_i <= 1'b1;
        SinkCoin: out_ready_i <= 1'($urandom_range(0, 1));
        default:  out_ready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i or negedge rst_ni) begin : au_monitor
    hevc_aua_out_t want;
    if (!rst_ni) begin
      results_owed <= 0;
      close_au();
    end else begin
      if (in_valid_i && in_ready_o) unit_exp_q.push_back(assemble_step(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (unit_exp_q.size() == 0) begin
          $error("result with no request waiting: 0x%0h", out_data_o);
          err_count++;
        end else begin
          want = unit_exp_q.pop_front();
          check_field("unit_ready", 32'(want.unit_ready), 32'(out_data_o.unit_ready));
          check_field("unit_dropped", 32'(want.unit_dropped),
                      32'(out_data_o.unit_dropped));
          check_field("unit_timestamp", want.unit_timestamp, out_data_o.unit_timestamp);
          check_field("unit_source_id", want.unit_source_id, out_data_o.unit_source_id);
          check_field("unit_profile_key", 32'(want.unit_profile_key),
                      32'(out_data_o.unit_profile_key));
          check_field("unit_byte_count", 32'(want.unit_byte_count),
                      32'(out_data_o.unit_byte_count));
          check_field("saw_vps", 32'(want.saw_vps), 32'(out_data_o.saw_vps));
          check_field("saw_sps", 32'(want.saw_sps), 32'(out_data_o.saw_sps));
          check_field("saw_pps", 32'(want.saw_pps), 32'(out_data_o.saw_pps));
          check_field("saw_irap", 32'(want.saw_irap), 32'(out_data_o.saw_irap));
          check_field("random_access_ready", 32'(want.random_access_ready),
                      32'(out_data_o.random_access_ready));
        end
      end
      results_owed <= unit_exp_q.size();
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_hevc_access_unit_assembler_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    hevc_aua_in_t p;
    int           next_drain;
    int           roll;
    logic         sat_done;

    // Empty unit closed by its marker: dropped
    queue_pkt(base_pkt('0, '0, '0, '0, 1'b1));
    // All-ones identity, break with nothing open, parameter sets in all lanes
    p = base_pkt('1, '1, '1, '1, 1'b0);
    p.discontinuity = 1'b1;
    p.nal_count     = 2'd3;
    p.nal_type_a    = NalVps;
    p.nal_type_b    = NalSps;
    p.nal_type_c    = NalPps;
    queue_pkt(p);
    // Lowest IRAP type in lane a only; lanes b and c must be ignored
    p = base_pkt('1, '1, '1, 16'd1, 1'b0);
    p.nal_count  = 2'd1;
    p.nal_type_a = NalIrapLo;
    p.nal_type_b = '1;
    p.nal_type_c = NalVps;
    queue_pkt(p);
    // Highest IRAP type, marker: unit emitted ready for random access
    p = base_pkt('1, '1, '1, 16'd2, 1'b1);
    p.nal_count  = 2'd2;
    p.nal_type_a = NalIrapHi;
    p.nal_type_b = NalIrapLo - 6'd1;
    queue_pkt(p);
    // Zero lane count ignores its types; boundary types outside IRAP
    p = base_pkt(32'd1000, 32'd5, 16'd7, 16'd10, 1'b0);
    p.nal_type_a = NalVps;
    queue_pkt(p);
    p = base_pkt(32'd1000, 32'd5, 16'd7, 16'd20, 1'b1);
    p.nal_count  = 2'd3;
    p.nal_type_a = NalIrapHi + 6'd1;
    p.nal_type_b = NalIrapLo - 6'd1;
    p.nal_type_c = NalPps + 6'd1;
    queue_pkt(p);
    // Timestamp change drops the open unit, marker completes the new one
    queue_pkt(base_pkt(32'd2000, 32'd5, 16'd7, 16'd5, 1'b0));
    queue_pkt(base_pkt(32'd2001, 32'd5, 16'd7, 16'd7, 1'b1));
    // SSRC change, profile change, then a break with a marker
    queue_pkt(base_pkt(32'd3000, 32'd9, 16'd7, 16'd1, 1'b0));
    queue_pkt(base_pkt(32'd3000, 32'd10, 16'd7, 16'd1, 1'b0));
    queue_pkt(base_pkt(32'd3000, 32'd10, 16'd8, 16'd1, 1'b0));
    p = base_pkt(32'd3000, 32'd10, 16'd8, 16'd3, 1'b1);
    p.discontinuity = 1'b1;
    queue_pkt(p);
    // Invalid payload: bytes and types ignored, unit dropped at its marker
    p = base_pkt(32'd4000, 32'd1, 16'd1, 16'd100, 1'b0);
    p.payload_valid = 1'b0;
    p.nal_count     = 2'd1;
    p.nal_type_a    = NalVps;
    queue_pkt(p);
    queue_pkt(base_pkt(32'd4000, 32'd1, 16'd1, 16'd4, 1'b1));
    // Fragment still open at the marker: dropped
    queue_pkt(base_pkt(32'd5000, 32'd1, 16'd1, 16'd4, 1'b0));
    p = base_pkt(32'd5000, 32'd1, 16'd1, 16'd4, 1'b1);
    p.fragment_open = 1'b1;
    queue_pkt(p);
    // Single invalid packet with a marker
    p = base_pkt(32'd6000, 32'd1, 16'd1, 16'd9, 1'b1);
    p.payload_valid = 1'b0;
    queue_pkt(p);
    // Marker with zero bytes but parameter sets seen
    p = base_pkt(32'd7000, 32'd1, 16'd1, '0, 1'b1);
    p.nal_count  = 2'd3;
    p.nal_type_a = NalVps;
    p.nal_type_b = NalSps;
    p.nal_type_c = NalPps;
    queue_pkt(p);
    // Zero identity emitted with one byte
    queue_pkt(base_pkt('0, '0, '0, 16'd1, 1'b1));
    // Leave a unit open so that the first random packet drops it
    p = base_pkt(32'hdead_beef, 32'h0bad_f00d, 16'hffff, '1, 1'b0);
    p.fragment_open = 1'b1;
    p.nal_count     = 2'd3;
    p.nal_type_a    = '1;
    p.nal_type_b    = '1;
    p.nal_type_c    = '1;
    queue_pkt(p);

    // Random part: mostly well-formed units, some noise, one saturating unit
    drain_next = 1'b1;
    sat_done   = 1'b0;
    next_drain = n_queued + $urandom_range(80, 160);
    while (n_queued < ITEM_TARGET) begin
      if (n_queued >= next_drain) begin
        drain_next = 1'b1;
        next_drain = n_queued + $urandom_range(80, 160);
      end
      roll = $urandom_range(0, 99);
      if (!sat_done && (n_queued >= 300 || (n_queued > 120 && roll < 10))) begin
        queue_saturating_unit();
        sat_done = 1'b1;
      end else if (roll < 12) begin
        queue_noise();
      end else begin
        queue_random_unit();
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go in and every result to come out
    do @(posedge clk_i); while (pkt_q.size() != 0 || in_valid_i || results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_hevc_access_unit_assembler_top: clean");
    end else begin
      $display("tb_hevc_access_unit_assembler_top: errors");
    end
    $finish;
  end

endmodule
